### design/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
package pba_pkg;

    localparam int unsigned CFG_W  = 11;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] TOP_BIT   = 32'h8000_0000;

    // Command codes
    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_ALLOC   = 3'd1;
    localparam logic [2:0] CMD_RESERVE = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_TEST    = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TOTAL_WORDS = 1'b0;
    localparam logic CFG_FIRST_FREE  = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] address;
    } pba_in_t;

    typedef struct packed {
        logic [31:0] page_address;
        logic        page_used;
        logic [1:0]  status;
    } pba_out_t;

    typedef enum logic [2:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_INIT,
        SQ_SCAN,
        SQ_ALLOC,
        SQ_PG_RD,
        SQ_PG_OP,
        SQ_RESULT
    } seq_state_t;

    typedef enum logic [1:0] {
        WOP_SET,
        WOP_CLR,
        WOP_ALLOC
    } word_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              bit_val;
        logic [4:0]        offset;
    } word_res_t;

endpackage

### design/pba_bitmap_ram.sv
// Bitmap word memory: one write port, one registered read port.
module pba_bitmap_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [pba_pkg::WORD_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [pba_pkg::WORD_W-1:0] rdata
);

    logic [pba_pkg::WORD_W-1:0] mem [DEPTH];
    logic [pba_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/pba_word_unit.sv
// Single-word bit unit: set, clear, or set first clear bit from the top.
module pba_word_unit (
    input  pba_pkg::word_op_t          op,
    input  logic [pba_pkg::WORD_W-1:0] word,
    input  logic [4:0]                 bit_pos,
    output pba_pkg::word_res_t         res
);

    always_comb begin
        logic [pba_pkg::WORD_W-1:0] v;
        logic [4:0]                 off;
        logic [4:0]                 pos;
        logic [pba_pkg::WORD_W-1:0] m;

        // leading-ones count, five halving steps
        v   = word;
        off = '0;
        if (v[31:16] == 16'hFFFF) begin
            off[4] = 1'b1;
            v      = {v[15:0], 16'h0000};
        end
        if (v[31:24] == 8'hFF) begin
            off[3] = 1'b1;
            v      = {v[23:0], 8'h00};
        end
        if (v[31:28] == 4'hF) begin
            off[2] = 1'b1;
            v      = {v[27:0], 4'h0};
        end
        if (v[31:30] == 2'b11) begin
            off[1] = 1'b1;
            v      = {v[29:0], 2'b00};
        end
        if (v[31]) begin
            off[0] = 1'b1;
        end

        pos = (op == pba_pkg::WOP_ALLOC) ? off : bit_pos;
        m   = pba_pkg::TOP_BIT >> pos;

        res.offset  = off;
        res.bit_val = |(word & m);
        res.word    = (op == pba_pkg::WOP_CLR) ? (word & ~m) : (word | m);
    end

endmodule

### design/page_bitmap_allocator.sv
// Page bitmap allocator top level: sequencer, config registers and result register.
//
// One bit per page (set = used), MAX_WORDS words of 32 pages, page size 1 << PAGE_SHIFT bytes,
// bits ordered most significant first. After reset the block sweeps the bitmap memory to all
// ones, one word per cycle; s_ready stays low during that pass while configuration writes are
// still taken. Items are handled one at a time: s_ready is high only while the sequencer is idle.
// Steps from acceptance to m_valid: reserve and release read the word, modify and write it
// back, then load the result; test reads the word and loads the bit without a write; an
// out-of-range page or an unknown command goes straight to loading the result; initialize
// writes one word per cycle over all MAX_WORDS words; allocate scans, reading one word per cycle
// through the memory's single read port up to the first word with a clear bit, writes that word
// back with its first clear bit set and loads the result; a full bitmap scans every live word.
// A finished result waits in the output register until taken; if the previous result is still
// waiting, the sequencer holds the new one until the register frees up.
// Configuration: cfg_index 0 is total_words, 1 is first_free_word; write only while idle.
module page_bitmap_allocator #(
    parameter int MAX_WORDS  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pba_pkg::pba_in_t               s_item,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output pba_pkg::pba_out_t              m_item,
    // configuration
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [pba_pkg::CFG_W-1:0]      cfg_wdata
);

    // word address width and a counter width that holds MAX_WORDS and any register value
    localparam int WIDX  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_A = $clog2(MAX_WORDS + 1);
    localparam int CNT_W = (CNT_A > pba_pkg::CFG_W) ? CNT_A : pba_pkg::CFG_W;
    localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(MAX_WORDS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_WORDS);

    // configuration registers
    logic [pba_pkg::CFG_W-1:0] total_words_reg;
    logic [pba_pkg::CFG_W-1:0] first_free_reg;

    // sequencer state
    pba_pkg::seq_state_t state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [WIDX-1:0]     chk_idx_reg, chk_idx_next;
    logic [WIDX-1:0]     widx_reg, widx_next;
    logic [pba_pkg::WORD_W-1:0] word_reg, word_next;
    logic [4:0]          bitpos_reg, bitpos_next;
    logic [2:0]          cmd_reg, cmd_next;
    pba_pkg::pba_out_t   res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    pba_pkg::pba_out_t   m_item_reg, m_item_next;

    // memory and word unit hookup
    logic                       ram_we;
    logic [WIDX-1:0]            ram_waddr;
    logic [pba_pkg::WORD_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [WIDX-1:0]            ram_raddr;
    logic [pba_pkg::WORD_W-1:0] ram_rdata;

    pba_pkg::word_op_t          wop;
    logic [pba_pkg::WORD_W-1:0] wu_word;
    pba_pkg::word_res_t         wres;

    // live word count: min(total_words, MAX_WORDS)
    logic [CNT_W-1:0] tw_ext;
    logic [CNT_W-1:0] ffw_ext;
    logic [CNT_W-1:0] words;
    assign tw_ext  = CNT_W'(total_words_reg);
    assign ffw_ext = CNT_W'(first_free_reg);
    assign words   = (tw_ext < MAX_CNT) ? tw_ext : MAX_CNT;

    // page decode of the incoming address
    logic [31:0] in_word_idx;
    logic        in_range_err;
    assign in_word_idx  = s_item.address >> (PAGE_SHIFT + 5);
    assign in_range_err = (in_word_idx >= 32'(words));

    // allocated page number and byte address
    logic [WIDX+4:0] alloc_page;
    logic [63:0]     alloc_addr;
    assign alloc_page = {widx_reg, wres.offset};
    assign alloc_addr = 64'(alloc_page) << PAGE_SHIFT;

    pba_bitmap_ram #(
        .DEPTH  (MAX_WORDS),
        .ADDR_W (WIDX)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign wu_word = (state_reg == pba_pkg::SQ_ALLOC) ? word_reg : ram_rdata;

    pba_word_unit u_word (
        .op      (wop),
        .word    (wu_word),
        .bit_pos (bitpos_reg),
        .res     (wres)
    );

    // configuration writes, taken in any state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_words_reg <= 11'd1024;
            first_free_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_index == pba_pkg::CFG_TOTAL_WORDS) begin
                total_words_reg <= cfg_wdata;
            end else begin
                first_free_reg <= cfg_wdata;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pba_pkg::SQ_CLEAR;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        chk_idx_reg <= chk_idx_next;
        widx_reg    <= widx_next;
        word_reg    <= word_next;
        bitpos_reg  <= bitpos_next;
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        m_item_reg  <= m_item_next;
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        widx_next      = widx_reg;
        word_next      = word_reg;
        bitpos_next    = bitpos_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        m_item_next    = m_item_reg;
        m_valid_next   = m_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg[WIDX-1:0];
        ram_wdata = pba_pkg::WORD_ONES;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[WIDX-1:0];
        wop       = pba_pkg::WOP_SET;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            pba_pkg::SQ_CLEAR: begin
                // post-reset sweep: every page used
                ram_we = 1'b1;
                if (idx_reg == LAST_WORD) begin
                    idx_next   = '0;
                    state_next = pba_pkg::SQ_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            pba_pkg::SQ_IDLE: begin
                if (s_valid) begin
                    cmd_next       = s_item.cmd;
                    bitpos_next    = s_item.address[PAGE_SHIFT+4:PAGE_SHIFT];
                    widx_next      = in_word_idx[WIDX-1:0];
                    res_next       = '0;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                    priority if (s_item.cmd == pba_pkg::CMD_INIT) begin
                        state_next = pba_pkg::SQ_INIT;
                    end else if (s_item.cmd == pba_pkg::CMD_ALLOC) begin
                        state_next = pba_pkg::SQ_SCAN;
                    end else if (s_item.cmd == pba_pkg::CMD_RESERVE ||
                                 s_item.cmd == pba_pkg::CMD_RELEASE ||
                                 s_item.cmd == pba_pkg::CMD_TEST) begin
                        if (in_range_err) begin
                            res_next.status = pba_pkg::STAT_RANGE;
                            state_next      = pba_pkg::SQ_RESULT;
                        end else begin
                            state_next = pba_pkg::SQ_PG_RD;
                        end
                    end else begin
                        // unknown command: all-zero result
                        state_next = pba_pkg::SQ_RESULT;
                    end
                end
            end

            pba_pkg::SQ_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = (idx_reg < ffw_ext || idx_reg >= words) ?
                            pba_pkg::WORD_ONES : '0;
                if (idx_reg == LAST_WORD) begin
                    idx_next   = '0;
                    state_next = pba_pkg::SQ_RESULT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            pba_pkg::SQ_SCAN: begin
                // issue one read per cycle, check the word read the cycle before
                priority if (chk_valid_reg && ram_rdata != pba_pkg::WORD_ONES) begin
                    word_next  = ram_rdata;
                    widx_next  = chk_idx_reg;
                    state_next = pba_pkg::SQ_ALLOC;
                end else if (idx_reg < words) begin
                    ram_re         = 1'b1;
                    chk_idx_next   = idx_reg[WIDX-1:0];
                    chk_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                end else if (!chk_valid_reg) begin
                    res_next.status = pba_pkg::STAT_FULL;
                    state_next      = pba_pkg::SQ_RESULT;
                end else begin
                    chk_valid_next = 1'b0;
                end
            end

            pba_pkg::SQ_ALLOC: begin
                wop                   = pba_pkg::WOP_ALLOC;
                ram_we                = 1'b1;
                ram_waddr             = widx_reg;
                ram_wdata             = wres.word;
                res_next.page_address = alloc_addr[31:0];
                state_next            = pba_pkg::SQ_RESULT;
            end

            pba_pkg::SQ_PG_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = widx_reg;
                state_next = pba_pkg::SQ_PG_OP;
            end

            pba_pkg::SQ_PG_OP: begin
                wop       = (cmd_reg == pba_pkg::CMD_RELEASE) ?
                            pba_pkg::WOP_CLR : pba_pkg::WOP_SET;
                ram_waddr = widx_reg;
                ram_wdata = wres.word;
                ram_we    = (cmd_reg != pba_pkg::CMD_TEST);
                if (cmd_reg == pba_pkg::CMD_TEST) begin
                    res_next.page_used = wres.bit_val;
                end
                state_next = pba_pkg::SQ_RESULT;
            end

            pba_pkg::SQ_RESULT: begin
                // load the output register once it is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = pba_pkg::SQ_IDLE;
                end
            end

            default: begin
                state_next = pba_pkg::SQ_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == pba_pkg::SQ_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
